// File: design/cau_pkg.sv
package cau_pkg;

	// operand and result format
	localparam int WIDTH = 16;
	localparam int FRAC = 12;
	// wide signed intermediate: sums of two full products
	localparam int SW = 2 * WIDTH + 1;
	// divisor |b|^2 fits in this many unsigned bits
	localparam int DW = 2 * WIDTH;
	// quotient bits kept: enough to decide saturation
	localparam int QW = WIDTH + 1;
	// scaled numerator width
	localparam int NW = DW + FRAC;

	typedef enum logic [2:0] {
		MODE_ADD  = 3'd0,
		MODE_SUB  = 3'd1,
		MODE_MUL  = 3'd2,
		MODE_DIV  = 3'd3,
		MODE_CONJ = 3'd4,
		MODE_NEG  = 3'd5,
		MODE_MAG  = 3'd6
	} mode_t;

	typedef struct packed {
		logic [2:0]              mode;
		logic signed [WIDTH-1:0] a_re;
		logic signed [WIDTH-1:0] a_im;
		logic signed [WIDTH-1:0] b_re;
		logic signed [WIDTH-1:0] b_im;
	} op_t;

	typedef struct packed {
		logic signed [WIDTH-1:0] res_re;
		logic signed [WIDTH-1:0] res_im;
		logic                    overflow;
		logic                    div_zero;
	} res_t;

	typedef struct packed {
		logic signed [WIDTH-1:0] val;
		logic                    ov;
	} sat_t;

	// clamp a wide signed value to the result range
	function automatic sat_t sat(input logic signed [SW-1:0] v);
		sat_t r;
		logic signed [SW-1:0] smax;
		logic signed [SW-1:0] smin;
		smax = SW'((1 << (WIDTH - 1)) - 1);
		smin = -smax - SW'(1);
		r.ov = 1'b0;
		if (v > smax) begin
			r.val = WIDTH'(smax);
			r.ov = 1'b1;
		end else if (v < smin) begin
			r.val = WIDTH'(smin);
			r.ov = 1'b1;
		end else begin
			r.val = WIDTH'(v);
		end
		return r;
	endfunction

endpackage

// File: design/complex_arith_unit_top.sv
// throughput: one item per cycle, busy is always low
// the divide uses a 17-stage restoring divider per result part, which sets latency
// reset: arst_n clears every valid bit at once; payload registers are not reset
// results appear for one cycle on done, the receiver cannot stall
module complex_arith_unit_top (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           start,
	output logic           busy,
	input  cau_pkg::op_t   op,
	output logic           done,
	output cau_pkg::res_t  res
);

	localparam int SW = cau_pkg::SW;
	localparam int DW = cau_pkg::DW;
	localparam int QW = cau_pkg::QW;
	localparam int NW = cau_pkg::NW;
	localparam int W  = cau_pkg::WIDTH;

	typedef struct packed {
		logic            valid;
		logic            is_div;
		logic            dz;
		logic            neg_re;
		logic            big_re;
		logic            neg_im;
		logic            big_im;
		cau_pkg::res_t   byp;
	} side_t;

	logic accept;
	assign busy = 1'b0;
	assign accept = start && !busy;

	// stage 1: products and the simple operations
	logic                  valid_s1;
	logic [2:0]            mode_s1;
	logic signed [2*W-1:0] p_arbr_s1, p_aibi_s1, p_aibr_s1, p_arbi_s1;
	logic signed [2*W-1:0] p_arar_s1, p_aiai_s1;
	logic signed [2*W-1:0] p_brbr_s1, p_bibi_s1;
	cau_pkg::res_t         simp_s1;

	logic signed [SW-1:0] ar_x, ai_x, br_x, bi_x;
	cau_pkg::sat_t        sre, sim;
	cau_pkg::res_t        simp_d;

	assign ar_x = SW'(op.a_re);
	assign ai_x = SW'(op.a_im);
	assign br_x = SW'(op.b_re);
	assign bi_x = SW'(op.b_im);

	always_comb begin
		sre = '0;
		sim = '0;
		case (op.mode)
			cau_pkg::MODE_ADD: begin
				sre = cau_pkg::sat(ar_x + br_x);
				sim = cau_pkg::sat(ai_x + bi_x);
			end
			cau_pkg::MODE_SUB: begin
				sre = cau_pkg::sat(ar_x - br_x);
				sim = cau_pkg::sat(ai_x - bi_x);
			end
			cau_pkg::MODE_CONJ: begin
				sre = cau_pkg::sat(ar_x);
				sim = cau_pkg::sat(-ai_x);
			end
			cau_pkg::MODE_NEG: begin
				sre = cau_pkg::sat(-ar_x);
				sim = cau_pkg::sat(-ai_x);
			end
			default: begin
				sre = '0;
				sim = '0;
			end
		endcase
		simp_d.res_re = sre.val;
		simp_d.res_im = sim.val;
		simp_d.overflow = sre.ov | sim.ov;
		simp_d.div_zero = 1'b0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= accept;
		end
	end

	always_ff @(posedge clk) begin
		mode_s1 <= op.mode;
		p_arbr_s1 <= op.a_re * op.b_re;
		p_aibi_s1 <= op.a_im * op.b_im;
		p_aibr_s1 <= op.a_im * op.b_re;
		p_arbi_s1 <= op.a_re * op.b_im;
		p_arar_s1 <= op.a_re * op.a_re;
		p_aiai_s1 <= op.a_im * op.a_im;
		p_brbr_s1 <= op.b_re * op.b_re;
		p_bibi_s1 <= op.b_im * op.b_im;
		simp_s1 <= simp_d;
	end

	// stage 2: sums of products and the divisor
	logic                 valid_s2;
	logic [2:0]           mode_s2;
	logic signed [SW-1:0] sum_re_s2, sum_im_s2;
	logic [DW-1:0]        den_s2;
	cau_pkg::res_t        simp_s2;

	logic signed [SW-1:0] x_arbr, x_aibi, x_aibr, x_arbi, x_arar, x_aiai;
	logic signed [SW-1:0] sum_re_d, sum_im_d;

	assign x_arbr = SW'(p_arbr_s1);
	assign x_aibi = SW'(p_aibi_s1);
	assign x_aibr = SW'(p_aibr_s1);
	assign x_arbi = SW'(p_arbi_s1);
	assign x_arar = SW'(p_arar_s1);
	assign x_aiai = SW'(p_aiai_s1);

	always_comb begin
		case (mode_s1)
			cau_pkg::MODE_MUL: begin
				sum_re_d = x_arbr - x_aibi;
				sum_im_d = x_aibr + x_arbi;
			end
			cau_pkg::MODE_DIV: begin
				sum_re_d = x_arbr + x_aibi;
				sum_im_d = x_aibr - x_arbi;
			end
			default: begin
				sum_re_d = x_arar + x_aiai;
				sum_im_d = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		mode_s2 <= mode_s1;
		sum_re_s2 <= sum_re_d;
		sum_im_s2 <= sum_im_d;
		den_s2 <= unsigned'(p_brbr_s1) + unsigned'(p_bibi_s1);
		simp_s2 <= simp_s1;
	end

	// stage 3: product results, divider set-up
	logic          valid_s3;
	side_t         side_s3;
	logic [DW-1:0] rem_re_s3, rem_im_s3, den_s3;
	logic [QW-1:0] low_re_s3, low_im_s3;

	cau_pkg::sat_t        pre, pim;
	cau_pkg::res_t        byp_d;
	logic [DW-1:0]        mag_re, mag_im;
	logic [NW-1:0]        num_re, num_im;
	logic [DW-1:0]        top_re, top_im;

	always_comb begin
		pre = cau_pkg::sat(sum_re_s2 >>> cau_pkg::FRAC);
		pim = cau_pkg::sat(sum_im_s2 >>> cau_pkg::FRAC);
		byp_d = simp_s2;
		case (mode_s2)
			cau_pkg::MODE_MUL: begin
				byp_d.res_re = pre.val;
				byp_d.res_im = pim.val;
				byp_d.overflow = pre.ov | pim.ov;
			end
			cau_pkg::MODE_MAG: begin
				byp_d.res_re = pre.val;
				byp_d.res_im = '0;
				byp_d.overflow = pre.ov;
			end
			default: begin
				byp_d = simp_s2;
			end
		endcase
		// numerator magnitudes scaled by the fraction bits
		mag_re = DW'(sum_re_s2[SW-1] ? -sum_re_s2 : sum_re_s2);
		mag_im = DW'(sum_im_s2[SW-1] ? -sum_im_s2 : sum_im_s2);
		num_re = {mag_re, cau_pkg::FRAC'(0)};
		num_im = {mag_im, cau_pkg::FRAC'(0)};
		top_re = DW'(num_re >> QW);
		top_im = DW'(num_im >> QW);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
		end else begin
			valid_s3 <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		side_s3.valid <= 1'b0;
		side_s3.is_div <= mode_s2 == cau_pkg::MODE_DIV;
		side_s3.dz <= den_s2 == '0;
		side_s3.neg_re <= sum_re_s2[SW-1];
		side_s3.neg_im <= sum_im_s2[SW-1];
		side_s3.big_re <= top_re >= den_s2;
		side_s3.big_im <= top_im >= den_s2;
		side_s3.byp <= byp_d;
		rem_re_s3 <= top_re;
		rem_im_s3 <= top_im;
		low_re_s3 <= num_re[QW-1:0];
		low_im_s3 <= num_im[QW-1:0];
		den_s3 <= den_s2;
	end

	// divider lanes
	logic [QW-1:0] quo_re, quo_im;

	cau_div_lane u_div_re (
		.clk    (clk),
		.rem_in (rem_re_s3),
		.low_in (low_re_s3),
		.den_in (den_s3),
		.quo    (quo_re)
	);

	cau_div_lane u_div_im (
		.clk    (clk),
		.rem_in (rem_im_s3),
		.low_in (low_im_s3),
		.den_in (den_s3),
		.quo    (quo_im)
	);

	// side information travels alongside the divider stages
	logic  valid_s4 [QW];
	side_t side_s4 [QW];

	for (genvar k = 0; k < QW; k++) begin : g_side
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				valid_s4[k] <= 1'b0;
			end else begin
				valid_s4[k] <= (k == 0) ? valid_s3 : valid_s4[(k == 0) ? 0 : k-1];
			end
		end

		always_ff @(posedge clk) begin
			side_s4[k] <= (k == 0) ? side_s3 : side_s4[(k == 0) ? 0 : k-1];
		end
	end

	// final sign and saturation of the quotients
	side_t                side_l;
	logic signed [SW-1:0] qv_re, qv_im;
	cau_pkg::sat_t        qre, qim;
	cau_pkg::res_t        res_d;

	assign side_l = side_s4[QW-1];

	always_comb begin
		qv_re = side_l.big_re ? SW'(1 << QW) : SW'(quo_re);
		qv_im = side_l.big_im ? SW'(1 << QW) : SW'(quo_im);
		if (side_l.neg_re) begin
			qv_re = -qv_re;
		end
		if (side_l.neg_im) begin
			qv_im = -qv_im;
		end
		qre = cau_pkg::sat(qv_re);
		qim = cau_pkg::sat(qv_im);
		if (!side_l.is_div) begin
			res_d = side_l.byp;
		end else if (side_l.dz) begin
			res_d = '0;
			res_d.div_zero = 1'b1;
		end else begin
			res_d.res_re = qre.val;
			res_d.res_im = qim.val;
			res_d.overflow = qre.ov | qim.ov;
			res_d.div_zero = 1'b0;
		end
	end

	logic done_q;
	cau_pkg::res_t res_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= valid_s4[QW-1];
		end
	end

	always_ff @(posedge clk) begin
		res_q <= res_d;
	end

	assign done = done_q;
	assign res = res_q;

	// every accepted item comes out a fixed time later
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		accept |-> ##21 done)
		else $error("item did not complete after pipeline latency");

	// a zero divisor gives a clean zero result
	a_div_zero: assert property (@(posedge clk) disable iff (!arst_n)
		done && res.div_zero |-> !res.overflow && res.res_re == '0 && res.res_im == '0)
		else $error("divide by zero result not clean");

	// done only follows a valid last divider stage
	a_done_src: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(valid_s4[QW-1]))
		else $error("done without a valid item in the last stage");

endmodule

// File: design/cau_div_lane.sv
module cau_div_lane (
	input  logic                       clk,
	input  logic [cau_pkg::DW-1:0]     rem_in,
	input  logic [cau_pkg::QW-1:0]     low_in,
	input  logic [cau_pkg::DW-1:0]     den_in,
	output logic [cau_pkg::QW-1:0]     quo
);

	// one restoring step per stage, one quotient bit per stage
	logic [cau_pkg::DW-1:0] rem_s [cau_pkg::QW];
	logic [cau_pkg::QW-1:0] low_s [cau_pkg::QW];
	logic [cau_pkg::DW-1:0] den_s [cau_pkg::QW];
	logic [cau_pkg::QW-1:0] quo_s [cau_pkg::QW];

	for (genvar k = 0; k < cau_pkg::QW; k++) begin : g_step
		logic [cau_pkg::DW-1:0] rem_prev;
		logic [cau_pkg::QW-1:0] low_prev;
		logic [cau_pkg::DW-1:0] den_prev;
		logic [cau_pkg::QW-1:0] quo_prev;
		logic [cau_pkg::DW:0]   trial;
		logic                   fits;

		if (k == 0) begin : g_first
			assign rem_prev = rem_in;
			assign low_prev = low_in;
			assign den_prev = den_in;
			assign quo_prev = '0;
		end else begin : g_next
			assign rem_prev = rem_s[k-1];
			assign low_prev = low_s[k-1];
			assign den_prev = den_s[k-1];
			assign quo_prev = quo_s[k-1];
		end

		// bring down the next numerator bit and try the subtract
		assign trial = {rem_prev, low_prev[cau_pkg::QW-1]};
		assign fits = trial >= {1'b0, den_prev};

		always_ff @(posedge clk) begin
			rem_s[k] <= fits ? cau_pkg::DW'(trial - {1'b0, den_prev}) : cau_pkg::DW'(trial);
			low_s[k] <= {low_prev[cau_pkg::QW-2:0], 1'b0};
			den_s[k] <= den_prev;
			quo_s[k] <= {quo_prev[cau_pkg::QW-2:0], fits};
		end
	end

	assign quo = quo_s[cau_pkg::QW-1];

endmodule

// File: tb/complex_arith_unit_top_test.sv
`timescale 1ns / 1ps

module complex_arith_unit_top_test;

	localparam int LATENCY = 21;
	localparam int N_RANDOM = 1430;
	localparam longint CYCLE_LIMIT = 200000;
	localparam logic [2:0] MODE_UNUSED = 3'd7;
	localparam logic signed [15:0] S_MAX = 16'sh7fff;
	localparam logic signed [15:0] S_MIN = -16'sh8000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic busy;
	cau_pkg::op_t op = '0;
	logic done;
	cau_pkg::res_t res;

	cau_pkg::res_t expected_q[$];
	int n_errors = 0;
	longint n_cycles = 0;

	// directed stimulus, with a typed-in answer where one is obvious
	typedef struct {
		cau_pkg::op_t  item;
		bit            fixed;
		cau_pkg::res_t answer;
	} row_t;
	row_t rows[$];

	complex_arith_unit_top DUT (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.op(op), .done(done), .res(res)
	);

	always #2 clk = ~clk;

	// clamp a wide value to the result range
	function automatic logic signed [15:0] clamp(input longint v, inout logic ov);
		if (v > 32767) begin
			ov = 1'b1;
			return S_MAX;
		end
		if (v < -32768) begin
			ov = 1'b1;
			return S_MIN;
		end
		return 16'(v);
	endfunction

	// quotient of n * 2^12 by d, truncated toward zero
	function automatic longint scaled_quotient(input longint n, input longint d);
		longint m;
		longint q;
		m = (n < 0) ? -n : n;
		q = (m <<< 12) / d;
		return (n < 0) ? -q : q;
	endfunction

	// complex result of one item
	function automatic cau_pkg::res_t complex_result(input cau_pkg::op_t x);
		cau_pkg::res_t r;
		logic ov;
		longint ar, ai, br, bi, d;
		ar = x.a_re; ai = x.a_im; br = x.b_re; bi = x.b_im;
		ov = 1'b0;
		r = '0;
		case (x.mode)
			cau_pkg::MODE_ADD: begin
				r.res_re = clamp(ar + br, ov);
				r.res_im = clamp(ai + bi, ov);
			end
			cau_pkg::MODE_SUB: begin
				r.res_re = clamp(ar - br, ov);
				r.res_im = clamp(ai - bi, ov);
			end
			cau_pkg::MODE_MUL: begin
				r.res_re = clamp((ar * br - ai * bi) >>> 12, ov);
				r.res_im = clamp((ai * br + ar * bi) >>> 12, ov);
			end
			cau_pkg::MODE_DIV: begin
				d = br * br + bi * bi;
				if (d == 0)
					r.div_zero = 1'b1;
				else begin
					r.res_re = clamp(scaled_quotient(ar * br + ai * bi, d), ov);
					r.res_im = clamp(scaled_quotient(ai * br - ar * bi, d), ov);
				end
			end
			cau_pkg::MODE_CONJ: begin
				r.res_re = clamp(ar, ov);
				r.res_im = clamp(-ai, ov);
			end
			cau_pkg::MODE_NEG: begin
				r.res_re = clamp(-ar, ov);
				r.res_im = clamp(-ai, ov);
			end
			cau_pkg::MODE_MAG: r.res_re = clamp((ar * ar + ai * ai) >>> 12, ov);
			default: ;
		endcase
		r.overflow = ov;
		return r;
	endfunction

	function automatic cau_pkg::op_t make_op(input logic [2:0] m,
		input logic [15:0] a, b, c, e);
		cau_pkg::op_t x;
		x.mode = m; x.a_re = a; x.a_im = b; x.b_re = c; x.b_im = e;
		return x;
	endfunction

	function automatic cau_pkg::res_t make_res(input logic [15:0] re, im,
		input logic ov, dz);
		cau_pkg::res_t r;
		r.res_re = re; r.res_im = im; r.overflow = ov; r.div_zero = dz;
		return r;
	endfunction

	task automatic add_row(input cau_pkg::op_t x, input bit fixed, input cau_pkg::res_t ans);
		row_t r;
		r.item = x; r.fixed = fixed; r.answer = ans;
		rows.push_back(r);
	endtask

	// random operand, often at or near an extreme
	function automatic logic [15:0] rand_operand();
		case ($urandom_range(0, 9))
			0: return 16'h8000;
			1: return 16'h7fff;
			2: return 16'(int'($urandom_range(0, 8)) - 4);
			3: return 16'(int'($urandom_range(0, 16384)) - 8192);
			default: return 16'($urandom);
		endcase
	endfunction

	// drive one item and wait for it to be taken
	task automatic send_item(input cau_pkg::op_t x, input bit fixed, input cau_pkg::res_t ans);
		int gap;
		gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 14);
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		start <= 1'b1;
		op <= x;
		@(posedge clk);
		while (busy) @(posedge clk);
		expected_q.push_back(fixed ? ans : complex_result(x));
		@(negedge clk);
	endtask

	// compare each result with the oldest expectation
	always @(posedge clk) begin
		cau_pkg::res_t e;
		if (arst_n && done) begin
			if (expected_q.size() == 0) begin
				$display("%0t: unexpected result %h", $time, res);
				n_errors++;
			end else begin
				e = expected_q.pop_front();
				if (res.res_re !== e.res_re) begin
					$display("%0t: res_re expected %h actual %h", $time, e.res_re, res.res_re);
					n_errors++;
				end
				if (res.res_im !== e.res_im) begin
					$display("%0t: res_im expected %h actual %h", $time, e.res_im, res.res_im);
					n_errors++;
				end
				if (res.overflow !== e.overflow) begin
					$display("%0t: overflow expected %b actual %b", $time, e.overflow,
						res.overflow);
					n_errors++;
				end
				if (res.div_zero !== e.div_zero) begin
					$display("%0t: div_zero expected %b actual %b", $time, e.div_zero,
						res.div_zero);
					n_errors++;
				end
			end
		end
	end

	// watchdog
	always @(posedge clk) begin
		n_cycles++;
		if (n_cycles > CYCLE_LIMIT) begin
			$display("end of test: mismatches");
			$finish;
		end
	end

	initial begin
		cau_pkg::op_t x;
		int wait_cycles;
		// extremes, every operation, zero divisor and unused opcode
		add_row(make_op(cau_pkg::MODE_ADD, S_MAX, S_MIN, 16'h0001, 16'hffff), 1'b1,
			make_res(S_MAX, S_MIN, 1'b1, 1'b0));
		add_row(make_op(cau_pkg::MODE_ADD, 16'h1000, 16'h0000, 16'h2000, 16'h0000), 1'b1,
			make_res(16'h3000, 16'h0000, 1'b0, 1'b0));
		add_row(make_op(cau_pkg::MODE_SUB, S_MIN, S_MAX, 16'h0001, 16'hffff), 1'b1,
			make_res(S_MIN, S_MAX, 1'b1, 1'b0));
		add_row(make_op(cau_pkg::MODE_SUB, 16'h1234, 16'h5678, 16'h1234, 16'h5678), 1'b1,
			make_res(16'h0000, 16'h0000, 1'b0, 1'b0));
		add_row(make_op(cau_pkg::MODE_MUL, S_MIN, S_MIN, S_MIN, S_MIN), 1'b0, '0);
		add_row(make_op(cau_pkg::MODE_MUL, 16'h1000, 16'h0000, 16'h1000, 16'h0000), 1'b1,
			make_res(16'h1000, 16'h0000, 1'b0, 1'b0));
		add_row(make_op(cau_pkg::MODE_MUL, 16'hffff, 16'h0001, 16'h0001, 16'h0001), 1'b0, '0);
		add_row(make_op(cau_pkg::MODE_MUL, S_MAX, S_MIN, S_MAX, S_MAX), 1'b0, '0);
		add_row(make_op(cau_pkg::MODE_DIV, S_MAX, S_MIN, 16'h0000, 16'h0000), 1'b1,
			make_res(16'h0000, 16'h0000, 1'b0, 1'b1));
		add_row(make_op(cau_pkg::MODE_DIV, 16'h1000, 16'h0000, 16'h1000, 16'h0000), 1'b1,
			make_res(16'h1000, 16'h0000, 1'b0, 1'b0));
		add_row(make_op(cau_pkg::MODE_DIV, S_MAX, S_MAX, 16'h0001, 16'h0000), 1'b1,
			make_res(S_MAX, S_MAX, 1'b1, 1'b0));
		add_row(make_op(cau_pkg::MODE_DIV, S_MIN, S_MIN, S_MIN, S_MIN), 1'b0, '0);
		add_row(make_op(cau_pkg::MODE_DIV, 16'hfffd, 16'h0007, 16'h0003, 16'hfff9), 1'b0, '0);
		add_row(make_op(cau_pkg::MODE_DIV, 16'h0001, 16'h0000, S_MAX, S_MIN), 1'b0, '0);
		add_row(make_op(cau_pkg::MODE_CONJ, S_MIN, S_MIN, 16'h0000, 16'h0000), 1'b1,
			make_res(S_MIN, S_MAX, 1'b1, 1'b0));
		add_row(make_op(cau_pkg::MODE_CONJ, S_MAX, S_MAX, S_MAX, S_MAX), 1'b1,
			make_res(S_MAX, 16'h8001, 1'b0, 1'b0));
		add_row(make_op(cau_pkg::MODE_NEG, S_MIN, 16'h0001, 16'h0000, 16'h0000), 1'b1,
			make_res(S_MAX, 16'hffff, 1'b1, 1'b0));
		add_row(make_op(cau_pkg::MODE_NEG, S_MAX, S_MIN, S_MIN, S_MIN), 1'b1,
			make_res(16'h8001, S_MAX, 1'b1, 1'b0));
		add_row(make_op(cau_pkg::MODE_MAG, S_MIN, S_MIN, 16'h0000, 16'h0000), 1'b1,
			make_res(S_MAX, 16'h0000, 1'b1, 1'b0));
		add_row(make_op(cau_pkg::MODE_MAG, 16'h1000, 16'hf000, S_MAX, S_MAX), 1'b1,
			make_res(16'h2000, 16'h0000, 1'b0, 1'b0));
		add_row(make_op(cau_pkg::MODE_MAG, 16'h0001, 16'hffff, 16'h0000, 16'h0000), 1'b1,
			make_res(16'h0000, 16'h0000, 1'b0, 1'b0));
		add_row(make_op(MODE_UNUSED, S_MIN, S_MAX, S_MIN, S_MAX), 1'b1,
			make_res(16'h0000, 16'h0000, 1'b0, 1'b0));
		add_row(make_op(MODE_UNUSED, 16'hffff, 16'hffff, 16'hffff, 16'hffff), 1'b1,
			make_res(16'h0000, 16'h0000, 1'b0, 1'b0));

		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		foreach (rows[i]) send_item(rows[i].item, rows[i].fixed, rows[i].answer);

		// random items, with runs of back-to-back items mixed in
		for (int i = 0; i < N_RANDOM; i++) begin
			x.mode = ($urandom_range(0, 19) == 0) ? MODE_UNUSED : 3'($urandom_range(0, 6));
			x.a_re = rand_operand();
			x.a_im = rand_operand();
			x.b_re = rand_operand();
			x.b_im = rand_operand();
			if (x.mode == cau_pkg::MODE_DIV && $urandom_range(0, 9) == 0) begin
				x.b_re = '0;
				x.b_im = '0;
			end
			send_item(x, 1'b0, '0);
		end
		start <= 1'b0;

		// drain, then let the pipeline settle
		wait_cycles = 0;
		while (expected_q.size() != 0 && wait_cycles < 10 * LATENCY + 100) begin
			@(posedge clk);
			wait_cycles++;
		end
		repeat (LATENCY + 4) @(posedge clk);
		if (n_errors == 0 && expected_q.size() == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

endmodule
